/* design/mcr_pkg.sv */
// Shared types, widths and constants of the midpoint circle rasterizer.
package mcr_pkg;

  // Width of the internal centre and point arithmetic; results wrap at this width.
  localparam int unsigned CoordBits  = 16;
  // Fixed field widths of the transactions.
  localparam int unsigned PortBits   = 16;
  localparam int unsigned RadiusBits = 12;
  localparam int unsigned OffBits    = 14;
  localparam int unsigned DecBits    = 16;
  // Eight mirrored points per offset pair.
  localparam int unsigned NumOctants = 8;
  localparam int unsigned OctBits    = $clog2(NumOctants);
  localparam logic [OctBits-1:0] OctLast = OctBits'(NumOctants - 1);

  // Midpoint update terms: 2*dx + 3 or 2*dx - 2*dy + 5.
  localparam logic signed [DecBits-1:0] DecIncHold = DecBits'(3);
  localparam logic signed [DecBits-1:0] DecIncMove = DecBits'(5);
  localparam logic signed [DecBits-1:0] DecOne     = DecBits'(1);

  typedef enum logic {
    ModeStart = 1'b0,
    ModeStep  = 1'b1
  } mode_e;

  typedef struct packed {
    mode_e                         mode;
    logic signed [PortBits-1:0]    center_col;
    logic signed [PortBits-1:0]    center_row;
    logic        [RadiusBits-1:0]  circle_radius;
  } in_t;

  typedef struct packed {
    logic signed [PortBits-1:0] point_x;
    logic signed [PortBits-1:0] point_y;
    logic        [OctBits-1:0]  octant;
    logic                       last;
    logic                       done_res;
  } out_t;

  // One offset pair to be mirrored into eight points.
  typedef struct packed {
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
    logic signed [OffBits-1:0]   off_x;
    logic signed [OffBits-1:0]   off_y;
    logic                        finish;
  } job_t;

endpackage

/* design/midpoint_circle_rasterizer.sv */
// Midpoint circle rasterizer top level: state update stage and eight-point serializer.
//
// A start transaction (mode 0) loads a centre and a radius and produces the
// eight mirrored points of the offset pair (0, radius); each following step
// transaction (mode 1) applies one midpoint update and produces the eight
// mirrored points of the new pair, with done_res on the eighth point of the
// step that finishes the circle. A step while no circle is running produces
// nothing. Every emitting transaction yields eight result transactions, one
// per cycle while the output is not stalled; the single output port, fed by
// the octant counter of the serializer, limits the rate. One job register
// sits between the update stage and the serializer, so the next input is
// taken while the current circle points are still going out. The first point
// of an item passes the job register, the current-job register and the output
// register before it appears on the output. Coordinates wrap at sixteen bits.
// There are no configuration registers.
module midpoint_circle_rasterizer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mcr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mcr_pkg::out_t out_data_o
);
  import mcr_pkg::*;

  // Job handoff between the update stage and the serializer.
  logic job_valid;
  logic job_take;
  job_t job;

  // The update stage holds the circle state and the midpoint decision value.
  mcr_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_take_i  (job_take)
  );

  // The serializer turns one offset pair into eight points in plotting order.
  mcr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_take_o  (job_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* design/mcr_step.sv */
// Circle state and the midpoint update, producing one job per emitting transaction.
module mcr_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mcr_pkg::in_t  in_data_i,
  output logic          job_valid_o,
  output mcr_pkg::job_t job_o,
  input  logic          job_take_i
);
  import mcr_pkg::*;

  logic signed [OffBits-1:0]   off_x_q, off_x_d;
  logic signed [OffBits-1:0]   off_y_q, off_y_d;
  logic signed [DecBits-1:0]   dec_q, dec_d;
  logic signed [CoordBits-1:0] cx_q, cx_d, cy_q, cy_d;
  logic                        active_q, active_d;
  logic                        job_valid_q, job_valid_d;
  job_t                        job_q, job_d;

  logic                        accept;
  logic                        is_start;
  logic                        emit;
  logic signed [DecBits-1:0]   dx_w, dy_w, dec_inc;
  logic signed [OffBits-1:0]   step_x, step_y;

  assign in_ready_o = !job_valid_q || job_take_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_start   = (in_data_i.mode == ModeStart);
  assign emit       = accept && (is_start || active_q);

  // Midpoint update of a running circle.
  always_comb begin
    dx_w = DecBits'(off_x_q);
    dy_w = DecBits'(off_y_q);
    if (dec_q > 0) begin
      dec_inc = (dx_w <<< 1) - (dy_w <<< 1) + DecIncMove;
      step_y  = off_y_q - OffBits'(1);
    end else begin
      dec_inc = (dx_w <<< 1) + DecIncHold;
      step_y  = off_y_q;
    end
    step_x = off_x_q + OffBits'(1);
  end

  always_comb begin
    off_x_d  = off_x_q;
    off_y_d  = off_y_q;
    dec_d    = dec_q;
    cx_d     = cx_q;
    cy_d     = cy_q;
    active_d = active_q;
    if (accept && is_start) begin
      cx_d     = CoordBits'(in_data_i.center_col);
      cy_d     = CoordBits'(in_data_i.center_row);
      off_x_d  = '0;
      off_y_d  = OffBits'(in_data_i.circle_radius);
      dec_d    = DecOne - DecBits'(in_data_i.circle_radius);
      active_d = 1'b1;
    end else if (accept && active_q) begin
      off_x_d  = step_x;
      off_y_d  = step_y;
      dec_d    = dec_q + dec_inc;
      active_d = !(step_y < step_x);
    end
  end

  always_comb begin
    job_d.cx     = cx_d;
    job_d.cy     = cy_d;
    job_d.off_x  = off_x_d;
    job_d.off_y  = off_y_d;
    job_d.finish = !is_start && (step_y < step_x);
    if (emit) begin
      job_valid_d = 1'b1;
    end else if (job_take_i) begin
      job_valid_d = 1'b0;
    end else begin
      job_valid_d = job_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_x_q     <= '0;
      off_y_q     <= '0;
      dec_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      active_q    <= 1'b0;
      job_valid_q <= 1'b0;
    end else begin
      off_x_q     <= off_x_d;
      off_y_q     <= off_y_d;
      dec_q       <= dec_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      active_q    <= active_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;

  // A start always leaves an active circle and a pending job behind.
  a_start_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_start |=> active_q && job_valid_q)
    else $error("start did not load a job");

  // A step while idle produces nothing.
  a_idle_step_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_start && !active_q && !job_valid_q |=> !job_valid_q)
    else $error("idle step produced a job");

  // While a completing job waits, the circle stays idle.
  a_finish_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && job_q.finish |-> !active_q)
    else $error("circle active behind a completing job");

endmodule

/* design/mcr_emit.sv */
// Serializer that mirrors one offset pair into eight points through an output register.
module mcr_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  mcr_pkg::job_t job_i,
  output logic          job_take_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mcr_pkg::out_t out_data_o
);
  import mcr_pkg::*;

  job_t                        cur_q;
  logic                        cur_valid_q, cur_valid_d;
  logic [OctBits-1:0]          cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;
  out_t                        out_q, out_d;

  logic                        load;
  logic                        end_job;
  logic signed [CoordBits-1:0] a_w, b_w, u_w, v_w, px, py;

  assign load       = cur_valid_q && (!out_valid_q || out_ready_i);
  assign end_job    = load && (cnt_q == OctLast);
  assign job_take_o = job_valid_i && (!cur_valid_q || end_job);

  // Octant bit 2 swaps the offsets, bit 0 picks the x sign, bit 1 the y sign.
  always_comb begin
    a_w = CoordBits'(cur_q.off_x);
    b_w = CoordBits'(cur_q.off_y);
    u_w = cnt_q[2] ? b_w : a_w;
    v_w = cnt_q[2] ? a_w : b_w;
    px  = cnt_q[0] ? (cur_q.cx + u_w) : (cur_q.cx - u_w);
    py  = cnt_q[1] ? (cur_q.cy - v_w) : (cur_q.cy + v_w);
    out_d.point_x  = PortBits'(px);
    out_d.point_y  = PortBits'(py);
    out_d.octant   = cnt_q;
    out_d.last     = (cnt_q == OctLast);
    out_d.done_res = (cnt_q == OctLast) && cur_q.finish;
  end

  always_comb begin
    if (job_take_o) begin
      cur_valid_d = 1'b1;
    end else if (end_job) begin
      cur_valid_d = 1'b0;
    end else begin
      cur_valid_d = cur_valid_q;
    end
    cnt_d = load ? cnt_q + OctBits'(1) : cnt_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      cur_q <= job_i;
    end
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The point counter rests at octant zero between jobs.
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_valid_q |-> cnt_q == '0)
    else $error("octant counter not at zero while idle");

  // The last flag marks exactly the eighth point.
  a_last_octant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.last == (out_q.octant == OctLast)))
    else $error("last flag off the eighth point");

  // Completion is only flagged on the eighth point.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> out_q.last)
    else $error("completion flagged before the eighth point");

endmodule
